>>> design/assert_macros.svh
// Assertion macros used by the checker file of the noise generator.
// Depends on nothing; each user supplies clk and rst in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define OVN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OVN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ovn_pkg.sv
// Package of the octave value noise generator: field widths, register codes,
// reset values, hash constants and the pipeline control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ovn_pkg;

  localparam int IDX_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int CELL_W     = 16;
  localparam int H_W        = 17;
  localparam int OUT_W      = 24;
  localparam int CNT_W      = 4;
  localparam int PERS_W     = 16;
  localparam int RANGE_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int POS_W      = CELL_W + FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZE   = 2'd2;

  localparam logic [CNT_W-1:0]   CNT_RESET   = 4'd8;
  localparam logic [PERS_W-1:0]  PERS_RESET  = 16'd42598;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 17'd1024;

  localparam logic [H_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [17:0]    SMOOTH_K = 18'd196608;

  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [31:0] HASH_TOP   = 32'h8000_0000;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> design/ovn_sample_if.sv
// Input channel of the noise generator: one sample index per item.
// Depends on ovn_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface ovn_sample_if;
  logic                        valid;
  logic                        ready;
  logic [ovn_pkg::IDX_W-1:0]   sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

`default_nettype wire

>>> design/ovn_noise_if.sv
// Output channel of the noise generator: one noise value per item.
// Depends on ovn_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface ovn_noise_if;
  logic                        valid;
  logic                        ready;
  logic [ovn_pkg::OUT_W-1:0]   noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

>>> design/ovn_div.sv
// Pipelined restoring divider: sample index scaled to the finest octave,
// divided by the range, one quotient bit per stage. Depends on ovn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ovn_div #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  ovn_pkg::pipe_ctl_t             ctl,
  input  wire  [ovn_pkg::IDX_W-1:0]            index,
  input  wire  [ovn_pkg::RANGE_W-1:0]          divisor,
  output logic [ovn_pkg::POS_W+MAX_OCTAVES-2:0] quotient,
  output logic                                 valid_out
);

  localparam int QW = ovn_pkg::POS_W + MAX_OCTAVES - 1;
  localparam int RW = ovn_pkg::RANGE_W;
  localparam int IW = ovn_pkg::IDX_W;

  logic [RW-1:0] rem [QW];
  logic [QW-1:0] quo [QW];
  logic [IW-1:0] idx [QW];
  logic          vld [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [IW-1:0] idx_in;
    logic          vld_in;
    logic [RW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign idx_in = index;
      assign vld_in = ctl.valid;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign quo_in = quo[i-1];
      assign idx_in = idx[i-1];
      assign vld_in = vld[i-1];
    end

    // Once the index bits are used up, zeros are shifted in from the right.
    assign trial = {rem_in, idx_in[IW-1]};
    assign take  = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (ctl.en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[i] <= take ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
        quo[i] <= {quo_in[QW-2:0], take};
        idx[i] <= {idx_in[IW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo[QW-1];
  assign valid_out = vld[QW-1];

endmodule

`default_nettype wire

>>> design/ovn_hash.sv
// Four-stage integer hash of one cell into a height in Q1.16.
// Depends on ovn_pkg for the hash constants.
`timescale 1ns / 1ps
`default_nettype none

module ovn_hash (
  input  wire                        clk,
  input  wire                        en,
  input  wire  [ovn_pkg::H_W-1:0]    cell_idx,
  output logic [ovn_pkg::H_W-1:0]    height
);

  localparam int NW = ovn_pkg::H_W + ovn_pkg::HASH_SHIFT;

  logic [NW-1:0]   n_c;
  logic [2*NW-1:0] sq_full;
  logic [NW-1:0]   n1;
  logic [NW-1:0]   n2;
  logic [31:0]     sq;
  logic [63:0]     inner_full;
  logic [31:0]     inner;
  logic [NW+31:0]  hv_full;
  logic [30:0]     hv;
  logic [31:0]     diff;

  assign n_c        = {cell_idx, {ovn_pkg::HASH_SHIFT{1'b0}}} ^ NW'(cell_idx);
  assign sq_full    = n_c * n_c;
  assign inner_full = sq * ovn_pkg::HASH_MUL_A;
  assign hv_full    = n2 * inner;
  assign diff       = ovn_pkg::HASH_TOP - {1'b0, hv};

  always_ff @(posedge clk) begin
    if (en) begin
      sq     <= sq_full[31:0];
      n1     <= n_c;
      inner  <= inner_full[31:0] + ovn_pkg::HASH_ADD_A;
      n2     <= n1;
      hv     <= hv_full[30:0] + ovn_pkg::HASH_ADD_B[30:0];
      height <= diff[31:15];
    end
  end

endmodule

`default_nettype wire

>>> design/ovn_octave.sv
// One octave lane: hashes both neighbouring cells, weights and blends them
// with the smoothstep of the fraction, and scales by the amplitude.
// Depends on ovn_pkg and ovn_hash; eight stages from cell to term.
`timescale 1ns / 1ps
`default_nettype none

module ovn_octave (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  ovn_pkg::pipe_ctl_t     ctl,
  input  wire  [ovn_pkg::CELL_W-1:0]   cell_idx,
  input  wire  [ovn_pkg::FRAC_W-1:0]   frac,
  input  wire  [ovn_pkg::H_W-1:0]      amp,
  output logic [ovn_pkg::H_W-1:0]      term,
  output logic                         valid_out
);

  localparam int HW    = ovn_pkg::H_W;
  localparam int FW    = ovn_pkg::FRAC_W;
  localparam int DEPTH = 8;

  logic [HW-1:0]   h0;
  logic [HW-1:0]   h1;
  logic [FW-1:0]   f1, f2, f3, f4;
  logic [2*FW-1:0] ff_full;
  logic [FW-1:0]   ff;
  logic [17:0]     wgt;
  logic [33:0]     sm_full;
  logic [HW-1:0]   sm2, sm3, sm4, sm5;
  logic [32:0]     u_full;
  logic [HW-1:0]   f_comp;
  logic [33:0]     v_full;
  logic [HW-1:0]   u, v;
  logic [33:0]     p0, p1;
  logic [34:0]     b_full;
  logic [HW-1:0]   b;
  logic [33:0]     t_full;
  logic            vld [DEPTH];

  ovn_hash u_hash_lo (
    .clk      (clk),
    .en       (ctl.en),
    .cell_idx ({1'b0, cell_idx}),
    .height   (h0)
  );

  // The upper cell does not wrap: it may reach one past the index range.
  ovn_hash u_hash_hi (
    .clk      (clk),
    .en       (ctl.en),
    .cell_idx (HW'({1'b0, cell_idx}) + HW'(1)),
    .height   (h1)
  );

  assign ff_full = frac * frac;
  assign wgt     = ovn_pkg::SMOOTH_K - {1'b0, f1, 1'b0};
  assign sm_full = ff * wgt;
  assign u_full  = h0 * f4;
  assign f_comp  = ovn_pkg::ONE_Q16 - {1'b0, f4};
  assign v_full  = h1 * f_comp;
  assign b_full  = p0 + p1;
  assign t_full  = b * amp;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ff   <= ff_full[2*FW-1:FW];
      f1   <= frac;
      sm2  <= sm_full[32:16];
      f2   <= f1;
      sm3  <= sm2;
      f3   <= f2;
      sm4  <= sm3;
      f4   <= f3;
      u    <= u_full[32:16];
      v    <= v_full[32:16];
      sm5  <= sm4;
      p0   <= u * (ovn_pkg::ONE_Q16 - sm5);
      p1   <= v * sm5;
      b    <= b_full[32:16];
      term <= t_full[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (ctl.en) begin
      vld[0] <= ctl.valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  assign valid_out = vld[DEPTH-1];

endmodule

`default_nettype wire

>>> design/octave_value_noise_1d.sv
// Fractal 1D value noise: one sample index in, one Q8.16 octave sum out.
// A new item is taken every cycle unless the output register holds a result
// that has not been taken. Each item passes in order through the position
// divider, the octave lanes, which all run in parallel, the octave sum
// register and the output register.
// Depends on ovn_pkg, the two channel interfaces, ovn_div and ovn_octave.
`timescale 1ns / 1ps
`default_nettype none

module octave_value_noise_1d #(
  parameter int MAX_OCTAVES = 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [ovn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [ovn_pkg::CFG_DATA_W-1:0]     cfg_data,
  ovn_sample_if.sink                         sample_in,
  ovn_noise_if.source                        noise_out
);

  localparam int QW    = ovn_pkg::POS_W + MAX_OCTAVES - 1;
  localparam int HW    = ovn_pkg::H_W;
  localparam int SUM_W = HW + $clog2(MAX_OCTAVES) + 1;
  localparam int OUT_W = ovn_pkg::OUT_W;

  logic [ovn_pkg::CNT_W-1:0]   octave_count;
  logic [ovn_pkg::PERS_W-1:0]  persistence;
  logic [ovn_pkg::RANGE_W-1:0] range_size;
  logic [ovn_pkg::RANGE_W-1:0] range_eff;

  logic                   en;
  logic [QW-1:0]          quotient;
  logic                   div_valid;
  logic [HW-1:0]          amp  [MAX_OCTAVES];
  logic [HW-1:0]          term [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] lane_vld;
  logic                   lane_valid;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       sum;
  logic                   sum_valid;
  logic                   out_valid;
  logic [OUT_W-1:0]       out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= ovn_pkg::CNT_RESET;
      persistence  <= ovn_pkg::PERS_RESET;
      range_size   <= ovn_pkg::RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ovn_pkg::REG_OCTAVE_COUNT: octave_count <= cfg_data[ovn_pkg::CNT_W-1:0];
        ovn_pkg::REG_PERSISTENCE:  persistence  <= cfg_data[ovn_pkg::PERS_W-1:0];
        ovn_pkg::REG_RANGE_SIZE:   range_size   <= cfg_data[ovn_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign range_eff = (range_size == '0) ? ovn_pkg::RANGE_W'(1) : range_size;

  // Octave amplitudes depend only on persistence. The chain settles after a
  // write well before an item taken with it reaches the lanes.
  always_ff @(posedge clk) begin
    amp[0] <= ovn_pkg::ONE_Q16;
  end

  for (genvar k = 1; k < MAX_OCTAVES; k++) begin : g_amp
    logic [HW+ovn_pkg::PERS_W-1:0] amp_prod;
    assign amp_prod = amp[k-1] * persistence;
    always_ff @(posedge clk) begin
      amp[k] <= amp_prod[HW+ovn_pkg::PERS_W-1:ovn_pkg::PERS_W];
    end
  end

  assign en              = !out_valid || noise_out.ready;
  assign sample_in.ready = en;

  // The finest octave's position is divided once; coarser octaves are
  // right shifts of that quotient, which floors the same way.
  ovn_div #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       ('{en: en, valid: sample_in.valid}),
    .index     (sample_in.sample_index),
    .divisor   (range_eff),
    .quotient  (quotient),
    .valid_out (div_valid)
  );

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    logic [ovn_pkg::POS_W-1:0] pos;
    assign pos = quotient[(MAX_OCTAVES-1-k) +: ovn_pkg::POS_W];

    ovn_octave u_octave (
      .clk       (clk),
      .rst       (rst),
      .ctl       ('{en: en, valid: div_valid}),
      .cell_idx  (pos[ovn_pkg::POS_W-1:ovn_pkg::FRAC_W]),
      .frac      (pos[ovn_pkg::FRAC_W-1:0]),
      .amp       (amp[k]),
      .term      (term[k]),
      .valid_out (lane_vld[k])
    );
  end

  // All lanes advance together, so their valid bits always agree.
  assign lane_valid = &lane_vld;

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) begin
      if ({1'b0, octave_count} > 5'(k)) begin
        sum_next = sum_next + SUM_W'(term[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= lane_valid;
      out_valid <= sum_valid;
    end
  end

  // Each term is at most one in Q1.16, so the sum stays far below the largest
  // value of the output field.
  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= sum_next;
      out_data <= OUT_W'(sum);
    end
  end

  assign noise_out.valid       = out_valid;
  assign noise_out.noise_value = out_data;

endmodule

`default_nettype wire

>>> design/ovn_checker.sv
// Port-level checks of the noise generator, bound to the top level.
// Depends on ovn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ovn_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [ovn_pkg::OUT_W-1:0]     out_data
);

  // The input side only stalls when a finished item is waiting.
  `OVN_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "input stalled wrongly")
  `OVN_ASSERT_RST(a_reset_empties, rst |=> !out_valid, "item shown right after reset")
  `OVN_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "waiting item dropped")
  `OVN_ASSERT(a_data_held, out_valid && !out_ready |=> $stable(out_data), "waiting item changed")

endmodule

bind octave_value_noise_1d ovn_checker u_ovn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_in.ready),
  .out_valid (noise_out.valid),
  .out_ready (noise_out.ready),
  .out_data  (noise_out.noise_value)
);

`default_nettype wire
